// ===== rtl/ipsa_pkg.sv =====
// Types, constants and helpers shared by the IPS patch stream applier.
package ipsa_pkg;

	localparam int unsigned ADDRESS_BITS = 24;
	localparam int unsigned SIZE_BITS = 16;
	localparam int unsigned IMAGE_BITS = ADDRESS_BITS + 1;
	localparam int unsigned PADDR_BITS = 3;
	localparam int unsigned PDATA_BITS = 32;

	localparam logic [IMAGE_BITS-1:0] IMAGE_SIZE_RESET = IMAGE_BITS'(1) << ADDRESS_BITS;
	localparam logic [ADDRESS_BITS-1:0] EOF_MARK = 24'h454F46;

	// Index of a configuration register, taken from paddr above the byte lanes.
	localparam logic REG_IMAGE_SIZE = 1'b0;

	localparam logic [7:0] CHAR_P = 8'h50;
	localparam logic [7:0] CHAR_A = 8'h41;
	localparam logic [7:0] CHAR_T = 8'h54;
	localparam logic [7:0] CHAR_C = 8'h43;
	localparam logic [7:0] CHAR_H = 8'h48;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_OFFSET,
		PH_SIZE,
		PH_DATA,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_BAD_HEADER,
		ST_TRUNCATED,
		ST_RLE
	} status_t;

	typedef enum logic {
		KIND_WRITE,
		KIND_FINISH
	} kind_t;

	typedef struct packed {
		kind_t                   kind;
		logic [ADDRESS_BITS-1:0] addr;
		logic [7:0]              data;
		status_t                 status;
		logic                    dropped;
	} result_t;

	// Expected character at each position of the PATCH header.
	function automatic logic [7:0] header_char(input logic [2:0] pos);
		logic [7:0] c;
		unique case (pos)
			3'd0: c = CHAR_P;
			3'd1: c = CHAR_A;
			3'd2: c = CHAR_T;
			3'd3: c = CHAR_C;
			3'd4: c = CHAR_H;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/ips_patch_stream_applier.sv =====
// IPS patch stream applier: header check, record parser and image write generator.
// The block takes one patch byte per cycle on the patch channel while the result channel
// keeps up and the spare slot is empty, and gives byte writes and a finish result on the
// result channel. A byte is held in an input register and decoded there by a small state
// machine; its results land in an output register backed by one spare slot. A byte gives
// at most one result, except a last byte that both writes and finishes early: it gives
// two results and holds the input register while the spare slot drains.
// image_size sits at byte address 0 of the APB port and must only be written while idle.
module ips_patch_stream_applier (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [ipsa_pkg::PADDR_BITS-1:0]     paddr,
	input  logic [ipsa_pkg::PDATA_BITS-1:0]     pwdata,
	output logic [ipsa_pkg::PDATA_BITS-1:0]     prdata,
	output logic                                pready,
	input  logic                                patch_valid,
	output logic                                patch_ready,
	input  logic [7:0]                          patch_byte,
	input  logic                                last,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic                                result_kind,
	output logic [ipsa_pkg::ADDRESS_BITS-1:0]   write_address,
	output logic [7:0]                          write_data,
	output logic [1:0]                          status,
	output logic                                some_dropped
);

	localparam int unsigned AB = ipsa_pkg::ADDRESS_BITS;
	localparam int unsigned IB = ipsa_pkg::IMAGE_BITS;
	localparam int unsigned SB = ipsa_pkg::SIZE_BITS;

	logic [IB-1:0]     image_size_q;
	logic              cfg_write;

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              last_s1;
	logic              go;

	ipsa_pkg::phase_t  phase_q, phase_d;
	logic [2:0]        byte_pos_q, byte_pos_d;
	logic [IB-1:0]     rec_addr_q, rec_addr_d;
	logic [SB-1:0]     remaining_q, remaining_d;
	logic              dropped_q, dropped_d;

	logic              write_v;
	logic              finish_v;
	ipsa_pkg::result_t write_res;
	ipsa_pkg::result_t finish_res;

	ipsa_pkg::result_t out_q;
	logic              out_v_q;
	ipsa_pkg::result_t pend_q;
	logic              pend_v_q;
	logic              out_take;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_size_q <= ipsa_pkg::IMAGE_SIZE_RESET;
		end else if (cfg_write && paddr[ipsa_pkg::PADDR_BITS-1] == ipsa_pkg::REG_IMAGE_SIZE) begin
			image_size_q <= pwdata[IB-1:0];
		end
	end

	always_comb begin
		if (paddr[ipsa_pkg::PADDR_BITS-1] == ipsa_pkg::REG_IMAGE_SIZE) begin
			prdata = ipsa_pkg::PDATA_BITS'(image_size_q);
		end else begin
			prdata = '0;
		end
	end

	// Input register. A byte is decoded once both result slots can take what it gives.
	assign out_take = out_v_q && result_ready;
	assign go = valid_s1 && !pend_v_q && (!out_v_q || result_ready);
	assign patch_ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (patch_ready) begin
			valid_s1 <= patch_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (patch_ready && patch_valid) begin
			byte_s1 <= patch_byte;
			last_s1 <= last;
		end
	end

	// Parser: next state and the results of the byte in the input register.
	always_comb begin
		logic [AB-1:0]   offset_new;
		logic [SB-1:0]   size_new;
		logic            finished;
		ipsa_pkg::status_t fin_status;

		phase_d     = phase_q;
		byte_pos_d  = byte_pos_q;
		rec_addr_d  = rec_addr_q;
		remaining_d = remaining_q;
		dropped_d   = dropped_q;
		write_v     = 1'b0;
		finished    = 1'b0;
		fin_status  = ipsa_pkg::ST_OK;
		offset_new  = (byte_pos_q == 3'd0) ? {{(AB-8){1'b0}}, byte_s1}
			: {rec_addr_q[AB-9:0], byte_s1};
		size_new    = {remaining_q[7:0], byte_s1};

		unique case (phase_q)
			ipsa_pkg::PH_HEADER: begin
				if (byte_pos_q > 3'd4 || byte_s1 != ipsa_pkg::header_char(byte_pos_q)) begin
					finished   = 1'b1;
					fin_status = ipsa_pkg::ST_BAD_HEADER;
				end else if (byte_pos_q == 3'd4) begin
					phase_d    = ipsa_pkg::PH_OFFSET;
					byte_pos_d = 3'd0;
				end else begin
					byte_pos_d = byte_pos_q + 3'd1;
				end
			end
			ipsa_pkg::PH_OFFSET: begin
				rec_addr_d = {1'b0, offset_new};
				if (byte_pos_q >= 3'd2) begin
					if (offset_new == ipsa_pkg::EOF_MARK) begin
						finished   = 1'b1;
						fin_status = ipsa_pkg::ST_OK;
					end else begin
						phase_d    = ipsa_pkg::PH_SIZE;
						byte_pos_d = 3'd0;
					end
				end else begin
					byte_pos_d = byte_pos_q + 3'd1;
				end
			end
			ipsa_pkg::PH_SIZE: begin
				if (byte_pos_q == 3'd0) begin
					remaining_d = {{(SB-8){1'b0}}, byte_s1};
					byte_pos_d  = 3'd1;
				end else begin
					remaining_d = size_new;
					byte_pos_d  = 3'd0;
					if (size_new == '0) begin
						finished   = 1'b1;
						fin_status = ipsa_pkg::ST_RLE;
					end else begin
						phase_d = ipsa_pkg::PH_DATA;
					end
				end
			end
			ipsa_pkg::PH_DATA: begin
				// The top address bit saturates, keeping runaway records beyond every image.
				if (rec_addr_q < image_size_q && !rec_addr_q[IB-1]) begin
					write_v = 1'b1;
				end else begin
					dropped_d = 1'b1;
				end
				if (!rec_addr_q[IB-1]) begin
					rec_addr_d = rec_addr_q + IB'(1);
				end
				remaining_d = remaining_q - SB'(1);
				if (remaining_d == '0) begin
					phase_d    = ipsa_pkg::PH_OFFSET;
					byte_pos_d = 3'd0;
				end
			end
			ipsa_pkg::PH_DONE: begin
				phase_d = ipsa_pkg::PH_DONE;
			end
			default: begin
				phase_d = ipsa_pkg::PH_DONE;
			end
		endcase

		finish_v = 1'b0;
		if (finished) begin
			finish_v   = 1'b1;
			phase_d    = ipsa_pkg::PH_DONE;
			byte_pos_d = 3'd0;
		end else if (last_s1 && phase_q != ipsa_pkg::PH_DONE) begin
			finish_v   = 1'b1;
			fin_status = ipsa_pkg::ST_TRUNCATED;
		end

		write_res.kind    = ipsa_pkg::KIND_WRITE;
		write_res.addr    = rec_addr_q[AB-1:0];
		write_res.data    = byte_s1;
		write_res.status  = ipsa_pkg::ST_OK;
		write_res.dropped = 1'b0;

		finish_res.kind    = ipsa_pkg::KIND_FINISH;
		finish_res.addr    = '0;
		finish_res.data    = 8'h00;
		finish_res.status  = fin_status;
		finish_res.dropped = dropped_d;

		if (last_s1) begin
			phase_d     = ipsa_pkg::PH_HEADER;
			byte_pos_d  = 3'd0;
			rec_addr_d  = '0;
			remaining_d = '0;
			dropped_d   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= ipsa_pkg::PH_HEADER;
			byte_pos_q  <= 3'd0;
			rec_addr_q  <= '0;
			remaining_q <= '0;
			dropped_q   <= 1'b0;
		end else if (go) begin
			phase_q     <= phase_d;
			byte_pos_q  <= byte_pos_d;
			rec_addr_q  <= rec_addr_d;
			remaining_q <= remaining_d;
			dropped_q   <= dropped_d;
		end
	end

	// Output register with one spare slot for the finish that trails a write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			pend_v_q <= 1'b0;
		end else if (go && (write_v || finish_v)) begin
			out_v_q  <= 1'b1;
			pend_v_q <= write_v && finish_v;
		end else if (out_take) begin
			out_v_q  <= pend_v_q;
			pend_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && (write_v || finish_v)) begin
			out_q  <= write_v ? write_res : finish_res;
			pend_q <= finish_res;
		end else if (out_take && pend_v_q) begin
			out_q <= pend_q;
		end
	end

	assign result_valid  = out_v_q;
	assign result_kind   = out_q.kind;
	assign write_address = out_q.addr;
	assign write_data    = out_q.data;
	assign status        = out_q.status;
	assign some_dropped  = out_q.dropped;

	a_pend_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> out_v_q)
		else $error("spare result slot holds a result while the output slot is empty");

	a_no_go_with_pend: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> !go)
		else $error("byte decoded while the spare result slot is full");

	a_done_pos_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == ipsa_pkg::PH_DONE) |-> (byte_pos_q == 3'd0))
		else $error("byte position left set after the patch finished");

	a_addr_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		rec_addr_q[IB-1] |-> (rec_addr_q[AB-1:0] == '0))
		else $error("record address ran on past its saturation point");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(go && last_s1) |=> (phase_q == ipsa_pkg::PH_HEADER && byte_pos_q == 3'd0
			&& dropped_q == 1'b0))
		else $error("parser state not cleared after the last byte of a stream");

endmodule
